/* rtl/core/tlpsa_pkg.sv */
// Package for the two-level page slot allocator.
// Holds the table sizes, derived widths, codes and the request and result word types.
// Used by the channel interfaces and by every module of the core.
package tlpsa_pkg;

  // Table sizes.
  localparam int PROCESSES = 4;
  localparam int ROWS      = 8;
  localparam int COLUMNS   = 32;

  // Derived sizes and widths.
  localparam int SLOTS      = ROWS * COLUMNS;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int PROC_IDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;

  // Fixed field widths of the request and result words.
  localparam int PROC_W  = 2;
  localparam int INDEX_W = 10;
  localparam int ADDR_W  = 10;

  // Request kinds.
  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_XLATE = 1'b1
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef logic [CNT_W-1:0] cnt_t;

  // One request word.
  typedef struct packed {
    kind_t                kind;
    logic [PROC_W-1:0]    process;
    logic [INDEX_W-1:0]   first_index;
    logic [INDEX_W-1:0]   second_index;
  } req_t;

  // One result word.
  typedef struct packed {
    status_t              status;
    logic [ADDR_W-1:0]    slot_addr;
  } rsp_t;

endpackage

/* rtl/core/tlpsa_if.sv */
// Valid/ready channel interfaces for the request and result words.
// Depends on tlpsa_pkg for the field widths and code types.

// Request channel.
interface tlpsa_req_if;
  import tlpsa_pkg::*;

  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic [PROC_W-1:0]    process;
  logic [INDEX_W-1:0]   first_index;
  logic [INDEX_W-1:0]   second_index;

  modport source (output valid, output kind, output process, output first_index,
                  output second_index, input ready);
  modport sink   (input valid, input kind, input process, input first_index,
                  input second_index, output ready);
endinterface

// Result channel.
interface tlpsa_rsp_if;
  import tlpsa_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [ADDR_W-1:0]    slot_addr;

  modport source (output valid, output status, output slot_addr, input ready);
  modport sink   (input valid, input status, input slot_addr, output ready);
endinterface

/* rtl/core/two_level_page_slot_allocator_core.sv */
// Top level of the two-level page slot allocator: input register, slot table, result register.
// Depends on tlpsa_pkg, tlpsa_if.sv and tlpsa_slot_table.
//
//   Channel  Dir  Handshake     Word fields
//   in_ch    in   valid/ready   kind, process, first_index, second_index
//   out_ch   out  valid/ready   status, slot_addr
//
// One word is accepted per cycle while out_ch.ready is high; a result passes through the input register
// and then the result register, and is taken from there when out_ch.ready is high.
// The rate is set by the per-process fill count, read and advanced in the same cycle.
// Reset clears all fill counts at once; there is no clearing pass.
// While the result register is held, the input register still takes a word, then stalls.
module two_level_page_slot_allocator_core (
  input logic        clk,
  input logic        rst_n,
  tlpsa_req_if.sink   in_ch,
  tlpsa_rsp_if.source out_ch
);
  import tlpsa_pkg::*;

  req_t in_req_r;
  logic in_vld_r;
  logic in_vld_nxt;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic out_vld_r;
  logic out_vld_nxt;
  logic in_acc;
  logic advance;

  // The held request moves on whenever the result register is free or being emptied.
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign in_vld_nxt  = in_acc ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign out_vld_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_req_r.kind         <= in_ch.kind;
      in_req_r.process      <= in_ch.process;
      in_req_r.first_index  <= in_ch.first_index;
      in_req_r.second_index <= in_ch.second_index;
    end
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  // Fill counts and the request decision.
  tlpsa_slot_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (in_req_r),
    .rsp   (rsp)
  );

  assign out_ch.valid     = out_vld_r;
  assign out_ch.status    = out_rsp_r.status;
  assign out_ch.slot_addr = out_rsp_r.slot_addr;

endmodule

/* rtl/core/tlpsa_slot_table.sv */
// Slot table of the allocator: one fill count per process and the request decision.
// Depends on tlpsa_pkg. Instantiated by two_level_page_slot_allocator_core.
module tlpsa_slot_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  tlpsa_pkg::req_t  req,
  output tlpsa_pkg::rsp_t  rsp
);
  import tlpsa_pkg::*;

  // Slots are only ever claimed first-fit and never released, so the used
  // slots of a process are always the prefix below its fill count.
  cnt_t                  count_r [PROCESSES];
  cnt_t                  count_nxt;
  cnt_t                  sel_cnt;
  cnt_t                  slot;
  cnt_t                  xl_slot;
  logic [PROC_IDX_W-1:0] proc_idx;
  logic                  proc_ok;
  logic                  idx_ok;
  logic                  bump;

  // Select the fill count of the addressed process.
  assign proc_ok  = 32'(req.process) < PROCESSES;
  assign proc_idx = PROC_IDX_W'(req.process);
  assign sel_cnt  = proc_ok ? count_r[proc_idx] : '0;

  // Translate: row-major slot number when both indices are in range.
  assign idx_ok  = (32'(req.first_index) < ROWS) && (32'(req.second_index) < COLUMNS);
  assign xl_slot = CNT_W'(32'(req.first_index) * COLUMNS + 32'(req.second_index));

  // Decide the result and whether the fill count moves.
  always_comb begin
    rsp.status    = ST_BAD;
    rsp.slot_addr = '0;
    slot          = '0;
    bump          = 1'b0;
    if (proc_ok) begin
      case (req.kind)
        KIND_ALLOC: begin
          if (sel_cnt < CNT_W'(SLOTS)) begin
            rsp.status = ST_OK;
            slot       = sel_cnt;
            bump       = 1'b1;
          end else begin
            rsp.status = ST_FULL;
          end
        end
        KIND_XLATE: begin
          if (idx_ok && (xl_slot < sel_cnt)) begin
            rsp.status = ST_OK;
            slot       = xl_slot;
          end
        end
        default: begin
          rsp.status = ST_BAD;
        end
      endcase
    end
    if (rsp.status == ST_OK) begin
      rsp.slot_addr = ADDR_W'(32'(req.process) * SLOTS + 32'(slot));
    end
  end

  assign count_nxt = sel_cnt + CNT_W'(1);

  // Fill counts; reset clears every process at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PROCESSES; i++) begin
        count_r[i] <= '0;
      end
    end else if (fire && bump) begin
      count_r[proc_idx] <= count_nxt;
    end
  end

  // A granted allocation moves the count of its process up by exactly one.
  a_alloc_bumps: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (req.kind == KIND_ALLOC) && (rsp.status == ST_OK))
      |=> (count_r[$past(proc_idx)] == $past(count_nxt)))
    else $error("fill count did not advance after a granted allocation");

  // A full answer only comes from a process whose table is used up.
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.status == ST_FULL) |-> (proc_ok && (sel_cnt == CNT_W'(SLOTS))))
    else $error("full status with free slots left");

  // A translate hit always points below the fill count.
  a_xlate_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
    ((req.kind == KIND_XLATE) && (rsp.status == ST_OK)) |-> (idx_ok && (xl_slot < sel_cnt)))
    else $error("translate hit on an unused slot");

  // No count ever runs past the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    proc_ok |-> (sel_cnt <= CNT_W'(SLOTS)))
    else $error("fill count beyond table size");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for two_level_page_slot_allocator_core: directed, random and fill traffic.
// Depends on tlpsa_pkg, the channel interfaces in tlpsa_if.sv and the core itself.
// A slot-table model predicts each result word, and a monitor compares it with the DUT output.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpsa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;

  tlpsa_req_if in_ch();
  tlpsa_rsp_if out_ch();

  two_level_page_slot_allocator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model of the slot table, and the result words still owed by the DUT.
  logic slot_busy [PROCESSES*SLOTS];
  rsp_t owed_results[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   idle_on = 1'b0;
  int   stall_left = 0;

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Claims the first free slot or looks up a used one, exactly as the block should.
  function automatic rsp_t grant_or_lookup(input kind_t k, input logic [PROC_W-1:0] p,
                                           input logic [INDEX_W-1:0] r,
                                           input logic [INDEX_W-1:0] c);
    rsp_t res;
    int   base;
    int   idx;
    res.status = ST_BAD;
    res.slot_addr = '0;
    if (int'(p) >= PROCESSES) begin
      return res;
    end
    base = int'(p) * SLOTS;
    if (k == KIND_ALLOC) begin
      res.status = ST_FULL;
      for (int s = 0; s < SLOTS; s++) begin
        if (!slot_busy[base + s]) begin
          slot_busy[base + s] = 1'b1;
          res.status = ST_OK;
          res.slot_addr = ADDR_W'(base + s);
          return res;
        end
      end
      return res;
    end
    if (int'(r) >= ROWS || int'(c) >= COLUMNS) begin
      return res;
    end
    idx = base + int'(r) * COLUMNS + int'(c);
    if (slot_busy[idx]) begin
      res.status = ST_OK;
      res.slot_addr = ADDR_W'(idx);
    end
    return res;
  endfunction

  // Slots are claimed in order, so the used slots of a process are the lowest ones.
  function automatic int slots_taken(input logic [PROC_W-1:0] p);
    int n;
    n = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_busy[int'(p) * SLOTS + s]) n++;
    end
    return n;
  endfunction

  // Offers one request word, waits for acceptance and records the expected result.
  task automatic send_word(input kind_t k, input logic [PROC_W-1:0] p,
                           input logic [INDEX_W-1:0] r, input logic [INDEX_W-1:0] c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= k;
    in_ch.process      <= p;
    in_ch.first_index  <= r;
    in_ch.second_index <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    owed_results.push_back(grant_or_lookup(k, p, r, c));
    @(negedge clk);
  endtask

  // One random request; allocations and translates of used slots dominate.
  task automatic send_random(input int alloc_pct, input int focus_pct,
                             input logic [PROC_W-1:0] focus);
    logic [PROC_W-1:0]  p;
    logic [INDEX_W-1:0] r;
    logic [INDEX_W-1:0] c;
    int taken;
    int s;
    int pick;
    p = ($urandom_range(1, 100) <= focus_pct) ? focus : PROC_W'($urandom_range(0, 3));
    if ($urandom_range(1, 100) <= alloc_pct) begin
      send_word(KIND_ALLOC, p, INDEX_W'($urandom), INDEX_W'($urandom));
    end else begin
      taken = slots_taken(p);
      pick = $urandom_range(0, 9);
      if (taken > 0 && pick < 6) begin
        s = $urandom_range(0, taken - 1);
        r = INDEX_W'(s / COLUMNS);
        c = INDEX_W'(s % COLUMNS);
      end else if (pick < 8) begin
        r = INDEX_W'($urandom_range(0, ROWS - 1));
        c = INDEX_W'($urandom_range(0, COLUMNS - 1));
      end else begin
        r = INDEX_W'($urandom);
        c = INDEX_W'($urandom);
      end
      send_word(KIND_XLATE, p, r, c);
    end
  endtask

  // Corner cases: unused slot zero, bounds on both indices, ignored indices on allocate.
  task automatic test_directed();
    send_word(KIND_XLATE, 2'd0, 10'd0, 10'd0);
    send_word(KIND_ALLOC, 2'd0, 10'd1023, 10'd1023);
    send_word(KIND_XLATE, 2'd0, 10'd0, 10'd0);
    send_word(KIND_ALLOC, 2'd0, 10'd0, 10'd0);
    send_word(KIND_XLATE, 2'd0, 10'd0, 10'd1);
    send_word(KIND_XLATE, 2'd0, 10'd8, 10'd0);
    send_word(KIND_XLATE, 2'd0, 10'd0, 10'd32);
    send_word(KIND_XLATE, 2'd0, 10'd1023, 10'd1023);
    send_word(KIND_XLATE, 2'd0, 10'd7, 10'd31);
    send_word(KIND_ALLOC, 2'd3, 10'd512, 10'd341);
    send_word(KIND_XLATE, 2'd3, 10'd0, 10'd0);
    send_word(KIND_XLATE, 2'd3, 10'd0, 10'd1);
    send_word(KIND_ALLOC, 2'd1, 10'd341, 10'd682);
    send_word(KIND_ALLOC, 2'd2, 10'd0, 10'd1023);
    send_word(KIND_XLATE, 2'd2, 10'd0, 10'd0);
    send_word(KIND_XLATE, 2'd1, 10'd0, 10'd0);
  endtask

  // Mixed traffic over all processes, with idling switched on and off in stretches.
  task automatic test_mixed_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      send_random(45, 0, 2'd0);
    end
  endtask

  // Drives process 3 to a full table, then checks the last slot and the full status.
  task automatic test_fill_process();
    int i;
    i = 0;
    while (slots_taken(2'd3) < SLOTS) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      send_random(85, 90, 2'd3);
      i++;
    end
    send_word(KIND_XLATE, 2'd3, 10'd7, 10'd31);
    send_word(KIND_ALLOC, 2'd3, 10'd0, 10'd0);
    for (int j = 0; j < 20; j++) begin
      send_random(60, 90, 2'd3);
    end
  endtask

  // Back-to-back words with neither side idling.
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_random(50, 30, 2'd3);
    end
  endtask

  // Result-side ready, with random stall bursts while idling is on.
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Checks every accepted result word against the oldest expected one.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result word: status %0d, slot_addr %0d",
               out_ch.status, out_ch.slot_addr);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.slot_addr !== want.slot_addr) begin
          $error("slot_addr: expected %0d, actual %0d", want.slot_addr, out_ch.slot_addr);
          mismatch_count++;
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reset, the test sequence and the final verdict.
  initial begin
    for (int i = 0; i < PROCESSES * SLOTS; i++) slot_busy[i] = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ALLOC;
    in_ch.process = '0;
    in_ch.first_index = '0;
    in_ch.second_index = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_on = 1'b1;
    test_directed();
    test_mixed_traffic(260);
    test_fill_process();
    test_back_to_back(60);
    in_ch.valid <= 1'b0;

    while (owed_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tlpsa_pkg.sv
rtl/core/tlpsa_if.sv
rtl/core/tlpsa_slot_table.sv
rtl/core/two_level_page_slot_allocator_core.sv
bench/tb_top.sv
